[hdl/vaos_pkg.sv]
// Shared constants and types for the voice allocator with oldest-note stealing.
package vaos_pkg;

   // Default sizes handed to the top level
   localparam int VOICES_DEF    = 16;
   localparam int TIME_BITS_DEF = 32;

   // Fixed field widths of the stream payloads
   localparam int VOICE_W      = 5;
   localparam int NOTE_W       = 7;
   localparam int START_W      = 32;
   localparam int REQ_TDATA_W  = 48;
   localparam int RSP_TDATA_W  = 16;

   // Voice count register
   localparam logic [VOICE_W-1:0] COUNT_RESET = 5'd16;

   // Command codes carried in req_tuser
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // Control from the top level into the scan sequencer
   typedef struct packed {
      logic start;   // allocate transfer accepted this cycle
      logic take;    // result moves into the output register this cycle
   } scan_ctl_type;

   // Result presented by the scan sequencer
   typedef struct packed {
      logic              valid;
      logic              stolen;
      logic [VOICE_W-1:0] voice;
      logic [NOTE_W-1:0]  note;
   } scan_res_type;

endpackage

[hdl/vaos_table.sv]
// Voice table: note and start-time memories with reset-cleared valid bits.
module vaos_table #(
   parameter int VOICES = vaos_pkg::VOICES_DEF,
   parameter int IW     = 4,
   parameter int SW     = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // write port
   input  logic                      wr_en,
   input  logic [IW-1:0]             wr_idx,
   input  logic [vaos_pkg::NOTE_W-1:0] wr_note,
   input  logic [SW-1:0]             wr_time,
   // steal clear
   input  logic                      clr_en,
   input  logic [IW-1:0]             clr_idx,
   // registered read port
   input  logic [IW-1:0]             rd_idx,
   output logic [vaos_pkg::NOTE_W-1:0] rd_note,
   output logic [SW-1:0]             rd_time
);

   logic [vaos_pkg::NOTE_W-1:0] note_ff  [VOICES];
   logic [SW-1:0]               time_ff  [VOICES];
   logic [VOICES-1:0]           valid_ff;
   logic [vaos_pkg::NOTE_W-1:0] note_q_ff;
   logic                        valid_q_ff;

   // Write the memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         note_ff[wr_idx] <= wr_note;
         time_ff[wr_idx] <= wr_time;
      end
   end

   // Track written entries; a steal frees its voice by dropping the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (clr_en) begin
            valid_ff[clr_idx] <= 1'b0;
         end
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      note_q_ff  <= note_ff[rd_idx];
      rd_time    <= time_ff[rd_idx];
      valid_q_ff <= valid_ff[rd_idx];
   end

   // An entry never written or stolen reads as a free voice
   assign rd_note = valid_q_ff ? note_q_ff : '0;

endmodule

[hdl/vaos_scan.sv]
// Scan sequencer: walks the voices one per cycle through a shared start-time comparator.
module vaos_scan #(
   parameter int VW     = 5,
   parameter int IW     = 4,
   parameter int SW     = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vaos_pkg::scan_ctl_type      ctl,
   input  logic [VW-1:0]               count,
   output logic                        busy,
   output vaos_pkg::scan_res_type      res,
   // table read
   output logic [IW-1:0]               rd_idx,
   input  logic [vaos_pkg::NOTE_W-1:0] rd_note,
   input  logic [SW-1:0]               rd_time,
   // steal clear
   output logic                        clr_en,
   output logic [IW-1:0]               clr_idx
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic [VW-1:0] VOICE_ONE = VW'(1);

   logic [1:0]                  state_ff, state_in;
   logic                        dir_ff, dir_in;
   logic [VW-1:0]               v_ff, v_in;
   logic [VW-1:0]               left_ff, left_in;
   logic                        prime_ff, prime_in;
   logic                        pend_ff, pend_in;
   logic [VW-1:0]               pv_ff, pv_in;
   logic [VW-1:0]               best_v_ff, best_v_in;
   logic [SW-1:0]               best_t_ff, best_t_in;
   logic [vaos_pkg::NOTE_W-1:0] best_n_ff, best_n_in;
   logic                        stolen_ff, stolen_in;
   logic [VW-1:0]               gv_ff, gv_in;
   logic [vaos_pkg::NOTE_W-1:0] gn_ff, gn_in;
   logic [VW-1:0]               rd_voice;
   logic                        older;

   // Shared comparator: strictly earlier start than the current candidate
   assign older = rd_time < best_t_ff;

   // Read voice one while idle to prime the candidate, else the scan pointer
   assign rd_voice = (state_ff == ST_SCAN && left_ff != '0) ? v_ff : VOICE_ONE;
   assign rd_idx   = IW'(rd_voice - VOICE_ONE);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      dir_in    = dir_ff;
      v_in      = v_ff;
      left_in   = left_ff;
      prime_in  = 1'b0;
      pend_in   = 1'b0;
      pv_in     = pv_ff;
      best_v_in = best_v_ff;
      best_t_in = best_t_ff;
      best_n_in = best_n_ff;
      stolen_in = stolen_ff;
      gv_in     = gv_ff;
      gn_in     = gn_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               dir_in   = ~dir_ff;
               v_in     = dir_ff ? VOICE_ONE : count;
               left_in  = count;
               prime_in = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue the next read
            if (left_ff != '0) begin
               pend_in = 1'b1;
               pv_in   = v_ff;
               v_in    = dir_ff ? (v_ff - VOICE_ONE) : (v_ff + VOICE_ONE);
               left_in = left_ff - VOICE_ONE;
            end
            // consume the data of the previous read
            priority if (prime_ff) begin
               best_v_in = VOICE_ONE;
               best_t_in = rd_time;
               best_n_in = rd_note;
            end else if (pend_ff) begin
               if (rd_note == '0) begin
                  stolen_in = 1'b0;
                  gv_in     = pv_ff;
                  gn_in     = '0;
                  pend_in   = 1'b0;
                  state_in  = ST_EMIT;
               end else if (older) begin
                  best_v_in = pv_ff;
                  best_t_in = rd_time;
                  best_n_in = rd_note;
               end
            end else if (left_ff == '0) begin
               // every voice busy: steal the oldest
               stolen_in = 1'b1;
               gv_in     = best_v_ff;
               gn_in     = best_n_ff;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dir_ff   <= 1'b1;
         prime_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
         prime_ff <= prime_in;
         pend_ff  <= pend_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      left_ff   <= left_in;
      pv_ff     <= pv_in;
      best_v_ff <= best_v_in;
      best_t_ff <= best_t_in;
      best_n_ff <= best_n_in;
      stolen_ff <= stolen_in;
      gv_ff     <= gv_in;
      gn_ff     <= gn_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign res.valid  = state_ff == ST_EMIT;
   assign res.stolen = stolen_ff;
   assign res.voice  = vaos_pkg::VOICE_W'(gv_ff);
   assign res.note   = gn_ff;

   // Free the stolen voice as its result leaves
   assign clr_en  = ctl.take & stolen_ff;
   assign clr_idx = IW'(gv_ff - VOICE_ONE);

endmodule

[hdl/voice_allocator_oldest_steal_unit.sv]
// Top level of the voice allocator with oldest-note stealing.
// A write transfer (req_tuser = 0) loads one voice's note and start time in the
// cycle it is accepted and gives no result. An allocate transfer (req_tuser = 1)
// flips the scan direction, then walks voices 1..N upward or downward (N = csr voice
// count, clamped to 1..VOICES) one per cycle through the single start-time comparator,
// taking a registered table read each cycle; it stops at the first free voice or, with
// none free, grants and frees the oldest. Alongside its first scan read it takes the
// read of voice 1 issued in the transfer cycle to prime the oldest candidate; after
// the scan reads it takes the last read, picks the oldest when none is free and hands
// the result off to the output register. req_tready is low all that time, and longer
// while the result waits for the output register to empty. The result sits in an
// output register, so a write transfer is still taken while it waits.
module voice_allocator_oldest_steal_unit #(
   parameter int VOICES    = vaos_pkg::VOICES_DEF,
   parameter int TIME_BITS = vaos_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [4:0] voice_index, [11:5] note_value, [43:12] start_time, [47:44] zero
   input  logic [vaos_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] cmd
   input  logic                              req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [4:0] granted_voice, [11:5] stolen_note, [15:12] zero
   output logic [vaos_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] was_stolen
   output logic                              rsp_tuser,
   // voice count register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vaos_pkg::VOICE_W-1:0]      csr_data
);

   localparam int VW = $clog2(VOICES + 1);
   localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SW = (TIME_BITS < vaos_pkg::START_W) ? TIME_BITS : vaos_pkg::START_W;

   logic [vaos_pkg::VOICE_W-1:0] count_ff, count_in;
   logic [VW-1:0]                eff_count;
   logic                         req_xfer;
   logic                         busy;
   vaos_pkg::scan_ctl_type       ctl;
   vaos_pkg::scan_res_type       res;
   logic [vaos_pkg::VOICE_W-1:0] wr_voice;
   logic                         wr_en;
   logic [IW-1:0]                rd_idx;
   logic [vaos_pkg::NOTE_W-1:0]  rd_note;
   logic [SW-1:0]                rd_time;
   logic                         clr_en;
   logic [IW-1:0]                clr_idx;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [vaos_pkg::VOICE_W-1:0] rsp_voice_ff, rsp_voice_in;
   logic [vaos_pkg::NOTE_W-1:0]  rsp_note_ff, rsp_note_in;
   logic                         rsp_stolen_ff, rsp_stolen_in;

   // Voice count register, always ready
   assign csr_ready = 1'b1;
   assign count_in  = csr_valid ? csr_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= vaos_pkg::COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // Clamp the count to 1..VOICES
   always_comb begin
      priority if (count_ff == '0) begin
         eff_count = VW'(1);
      end else if (32'(count_ff) > VOICES) begin
         eff_count = VW'(VOICES);
      end else begin
         eff_count = VW'(count_ff);
      end
   end

   // Request transfer and decode
   assign req_tready = ~busy;
   assign req_xfer   = req_tvalid & req_tready;
   assign wr_voice   = req_tdata[4:0];
   assign wr_en      = req_xfer & (req_tuser == vaos_pkg::CMD_WRITE) & (wr_voice != '0)
                     & (32'(wr_voice) <= VOICES);

   assign ctl.start = req_xfer & (req_tuser == vaos_pkg::CMD_ALLOC);
   assign ctl.take  = res.valid & (~rsp_tvalid_ff | rsp_tready);

   vaos_table #(
      .VOICES (VOICES),
      .IW     (IW),
      .SW     (SW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_idx  (IW'(wr_voice - 5'd1)),
      .wr_note (req_tdata[11:5]),
      .wr_time (SW'(req_tdata[43:12])),
      .clr_en  (clr_en),
      .clr_idx (clr_idx),
      .rd_idx  (rd_idx),
      .rd_note (rd_note),
      .rd_time (rd_time)
   );

   vaos_scan #(
      .VW     (VW),
      .IW     (IW),
      .SW     (SW)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .count   (eff_count),
      .busy    (busy),
      .res     (res),
      .rd_idx  (rd_idx),
      .rd_note (rd_note),
      .rd_time (rd_time),
      .clr_en  (clr_en),
      .clr_idx (clr_idx)
   );

   // Output register: load a result, hold it until the transfer
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_voice_in  = rsp_voice_ff;
      rsp_note_in   = rsp_note_ff;
      rsp_stolen_in = rsp_stolen_ff;
      if (ctl.take) begin
         rsp_tvalid_in = 1'b1;
         rsp_voice_in  = res.voice;
         rsp_note_in   = res.note;
         rsp_stolen_in = res.stolen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_voice_ff  <= rsp_voice_in;
      rsp_note_ff   <= rsp_note_in;
      rsp_stolen_ff <= rsp_stolen_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, rsp_note_ff, rsp_voice_ff};
   assign rsp_tuser  = rsp_stolen_ff;

endmodule

[tb/voice_allocator_oldest_steal_unit_tb.sv]
// Self-checking testbench for the voice allocator with oldest-note stealing.
module voice_allocator_oldest_steal_unit_tb;

   localparam int VOICES      = vaos_pkg::VOICES_DEF;
   localparam int VOICE_W     = vaos_pkg::VOICE_W;
   localparam int NOTE_W      = vaos_pkg::NOTE_W;
   localparam int START_W     = vaos_pkg::START_W;
   localparam int REQ_TDATA_W = vaos_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = vaos_pkg::RSP_TDATA_W;
   localparam int SETTLE      = VOICES + 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 95;
   localparam int NROWS       = 22;

   // One grant as seen on the response stream
   typedef struct packed {
      logic [VOICE_W-1:0] voice;
      logic               stolen;
      logic [NOTE_W-1:0]  note;
   } grant_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_ALLOC, ROW_COUNT} row_kind_type;

   // Directed row: a request, or a voice count write carried in idx
   typedef struct packed {
      row_kind_type       kind;
      logic [VOICE_W-1:0] idx;
      logic [NOTE_W-1:0]  note;
      logic [START_W-1:0] start;
      logic               typed;
      grant_type          want;
   } row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = vaos_pkg::CMD_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [VOICE_W-1:0]     csr_data   = vaos_pkg::COUNT_RESET;

   // Shadow of the voice table, scan direction and voice count
   logic [NOTE_W-1:0]  note_tab  [1:VOICES];
   logic [START_W-1:0] start_tab [1:VOICES];
   logic               scan_dn;
   logic [VOICE_W-1:0] count_reg;

   grant_type          grant_q [$];
   int                 errors      = 0;
   int                 cycle_count = 0;
   int                 idle_pct    = 20;
   int                 stall_left  = 0;
   logic [VOICE_W-1:0] last_grant  = 5'd1;
   logic               fill_pending = 1'b0;
   logic [START_W-1:0] song_time   = '0;
   row_type            dir_rows [0:NROWS-1];

   voice_allocator_oldest_steal_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Clamp the voice count register to the voices actually scanned
   function automatic int scanned_voices(logic [VOICE_W-1:0] count);
      if (count == 0) return 1;
      if (count > VOICES) return VOICES;
      return count;
   endfunction

   // Flip direction, grant the first free voice, else steal the oldest
   function automatic grant_type allocate_voice();
      int                 n;
      int                 v;
      int                 best;
      logic [START_W-1:0] best_start;
      grant_type          g;
      scan_dn    = ~scan_dn;
      n          = scanned_voices(count_reg);
      best       = 1;
      best_start = start_tab[1];
      for (int k = 0; k < n; k++) begin
         v = scan_dn ? n - k : k + 1;
         if (note_tab[v] == '0) begin
            g.voice  = VOICE_W'(v);
            g.stolen = 1'b0;
            g.note   = '0;
            return g;
         end
         if (start_tab[v] < best_start) begin
            best_start = start_tab[v];
            best       = v;
         end
      end
      g.voice        = VOICE_W'(best);
      g.stolen       = 1'b1;
      g.note         = note_tab[best];
      note_tab[best] = '0;
      return g;
   endfunction

   function automatic void flag_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endfunction

   // Offer one request, hold it until transferred, then update the shadow
   task automatic put_request(logic cmd, logic [VOICE_W-1:0] idx, logic [NOTE_W-1:0] note,
                              logic [START_W-1:0] start, logic typed, grant_type want);
      grant_type g;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, start, note, idx};
      do @(posedge clock); while (!req_tready);
      if (cmd == vaos_pkg::CMD_WRITE) begin
         if (idx >= 1 && idx <= VOICES) begin
            note_tab[idx]  = note;
            start_tab[idx] = start;
         end
      end else begin
         g = allocate_voice();
         grant_q.push_back(typed ? want : g);
         last_grant   = g.voice;
         fill_pending = 1'b1;
      end
   endtask

   // Drop the request side and let every outstanding grant come out
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_voice_count(logic [VOICE_W-1:0] count);
      drain_block();
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_reg = count;
   endtask

   // Mostly note-on sequences: allocate, then load the granted voice
   task automatic random_event();
      int                 pick;
      int                 mode;
      int                 n;
      logic [VOICE_W-1:0] idx;
      logic [NOTE_W-1:0]  note;
      logic [START_W-1:0] start;
      n    = scanned_voices(count_reg);
      pick = $urandom_range(0, 99);
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
         song_time += $urandom_range(0, 3);
         start = song_time;
      end else if (mode < 8) begin
         start = $urandom;
      end else begin
         start = (mode == 8) ? '0 : '1;
      end
      note = ($urandom_range(0, 6) == 0) ? '0 : NOTE_W'($urandom_range(1, 127));
      if (fill_pending && $urandom_range(0, 9) < 8) begin
         put_request(vaos_pkg::CMD_WRITE, last_grant, NOTE_W'($urandom_range(1, 127)), start,
                     1'b0, '0);
         fill_pending = 1'b0;
      end else if (pick < 40) begin
         put_request(vaos_pkg::CMD_ALLOC, VOICE_W'($urandom), NOTE_W'($urandom), $urandom,
                     1'b0, '0);
      end else begin
         if (pick < 90) idx = VOICE_W'($urandom_range(1, n));
         else if (pick < 95) idx = VOICE_W'($urandom_range(1, VOICES));
         else idx = $urandom_range(0, 1) ? '0 : VOICE_W'($urandom_range(VOICES + 1, 31));
         put_request(vaos_pkg::CMD_WRITE, idx, note, start, 1'b0, '0);
      end
   endtask

   // Check each response transfer and stall the response side in bursts
   always @(posedge clock) begin
      grant_type seen;
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tdata[4:0], rsp_tuser, rsp_tdata[11:5]};
         if (grant_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected grant voice %0d stolen %0d note %0d",
                                    seen.voice, seen.stolen, seen.note));
         end else begin
            want = grant_q.pop_front();
            if (seen.voice !== want.voice || seen.stolen !== want.stolen ||
                seen.note !== want.note)
               flag_mismatch($sformatf("voice %0d stolen %0d note %0d, expected %0d %0d %0d",
                                       seen.voice, seen.stolen, seen.note,
                                       want.voice, want.stolen, want.note));
         end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
         stall_left = $urandom_range(1, 10);
      rsp_tready <= (stall_left == 0);
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("voice_allocator_oldest_steal_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      static int phase_count [PHASES] = '{1, 16, 0, 31, 2, 8, 0, 16};
      static int phase_idle  [PHASES] = '{25, 0, 40, 10, 60, 20, 30, 0};
      row_type r;
      dir_rows = '{
         // all free after reset: first scan up, then down
         '{ROW_ALLOC, 5'd0,  7'd0,   32'd0,          1'b1, '{5'd1,  1'b0, 7'd0}},
         '{ROW_ALLOC, 5'd31, 7'd127, 32'hFFFFFFFF,   1'b1, '{5'd16, 1'b0, 7'd0}},
         // index out of range: ignored; voice 1 loaded, so the scan up grants voice 2
         '{ROW_WRITE, 5'd0,  7'd5,   32'd3,          1'b0, '0},
         '{ROW_WRITE, 5'd31, 7'd127, 32'hFFFFFFFF,   1'b0, '0},
         '{ROW_WRITE, 5'd1,  7'd127, 32'hFFFFFFFF,   1'b0, '0},
         '{ROW_ALLOC, 5'd0,  7'd0,   32'd0,          1'b1, '{5'd2,  1'b0, 7'd0}},
         // count of zero acts as one voice: steal voice 1
         '{ROW_COUNT, 5'd0,  7'd0,   32'd0,          1'b0, '0},
         '{ROW_ALLOC, 5'd0,  7'd0,   32'd0,          1'b1, '{5'd1,  1'b1, 7'd127}},
         '{ROW_ALLOC, 5'd0,  7'd0,   32'd0,          1'b1, '{5'd1,  1'b0, 7'd0}},
         // three voices, equal starts: voice 1 kept on the tie
         '{ROW_COUNT, 5'd3,  7'd0,   32'd0,          1'b0, '0},
         '{ROW_WRITE, 5'd1,  7'd10,  32'd5,          1'b0, '0},
         '{ROW_WRITE, 5'd2,  7'd20,  32'd5,          1'b0, '0},
         '{ROW_WRITE, 5'd3,  7'd30,  32'd5,          1'b0, '0},
         '{ROW_ALLOC, 5'd0,  7'd0,   32'd0,          1'b1, '{5'd1,  1'b1, 7'd10}},
         // earliest start wins
         '{ROW_WRITE, 5'd1,  7'd40,  32'd9,          1'b0, '0},
         '{ROW_WRITE, 5'd3,  7'd50,  32'd2,          1'b0, '0},
         '{ROW_ALLOC, 5'd0,  7'd0,   32'd0,          1'b1, '{5'd3,  1'b1, 7'd50}},
         // note off, then a stolen voice counts as free
         '{ROW_WRITE, 5'd2,  7'd0,   32'd0,          1'b0, '0},
         '{ROW_ALLOC, 5'd0,  7'd0,   32'd0,          1'b1, '{5'd3,  1'b0, 7'd0}},
         // count above the table size acts as all voices
         '{ROW_COUNT, 5'd31, 7'd0,   32'd0,          1'b0, '0},
         '{ROW_WRITE, 5'd16, 7'd127, 32'd0,          1'b0, '0},
         '{ROW_ALLOC, 5'd0,  7'd0,   32'd0,          1'b0, '0}
      };
      for (int v = 1; v <= VOICES; v++) begin
         note_tab[v]  = '0;
         start_tab[v] = '0;
      end
      scan_dn   = 1'b1;
      count_reg = vaos_pkg::COUNT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NROWS; i++) begin
         r = dir_rows[i];
         case (r.kind)
            ROW_COUNT: set_voice_count(r.idx);
            ROW_WRITE: put_request(vaos_pkg::CMD_WRITE, r.idx, r.note, r.start, r.typed,
                                   r.want);
            default:   put_request(vaos_pkg::CMD_ALLOC, r.idx, r.note, r.start, r.typed,
                                   r.want);
         endcase
      end

      // random phases, one voice count each; the last runs without idling
      for (int p = 0; p < PHASES; p++) begin
         if (p == 6) set_voice_count(VOICE_W'($urandom_range(0, 31)));
         else set_voice_count(VOICE_W'(phase_count[p]));
         idle_pct = phase_idle[p];
         repeat (PHASE_ITEMS) random_event();
      end

      drain_block();
      if (errors == 0) begin
         $display("voice_allocator_oldest_steal_unit_tb: done, clean");
      end else begin
         $display("voice_allocator_oldest_steal_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
